>>> sv/dtcheck_pkg.sv
// ----------------------------------------------------------------------------
// dtcheck_pkg
// Shared types for the date-time checker: record in, result out, and the
// classified record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package dtcheck_pkg;

  localparam int unsigned DateW  = 28;  // yyyymmdd, year up to 16383
  localparam int unsigned TodW   = 19;  // hhmmss, fields up to their bit range
  localparam int unsigned StampW = 47;
  localparam int unsigned CountW = 32;
  localparam int unsigned SumW   = 40;
  localparam int unsigned AmtW   = 24;
  localparam int unsigned IdW    = 16;

  typedef struct packed {
    logic [4:0]      day_of_month;
    logic [3:0]      month_num;
    logic [13:0]     year_num;
    logic [4:0]      hour_num;
    logic [5:0]      minute_num;
    logic [5:0]      second_num;
    logic [IdW-1:0]  record_id;
    logic [AmtW-1:0] amount_cents;
  } rec_in_t;

  typedef struct packed {
    logic              record_valid;
    logic [StampW-1:0] record_stamp;
    logic [CountW-1:0] valid_total_count;
    logic [CountW-1:0] invalid_total_count;
    logic [SumW-1:0]   amount_sum;
    logic [AmtW-1:0]   largest_amount;
    logic [IdW-1:0]    largest_id;
    logic [StampW-1:0] largest_stamp;
    logic [AmtW-1:0]   smallest_amount;
    logic [IdW-1:0]    smallest_id;
    logic [StampW-1:0] smallest_stamp;
  } rec_out_t;

  // Classified record: check verdict plus the two halves of the decimal key.
  typedef struct packed {
    logic             ok;
    logic [DateW-1:0] date;
    logic [TodW-1:0]  tod;
    logic [IdW-1:0]   record_id;
    logic [AmtW-1:0]  amount_cents;
  } cls_t;

endpackage

`default_nettype wire

>>> sv/dtcheck_front.sv
// ----------------------------------------------------------------------------
// dtcheck_front
// Calendar check of one record and the decimal yyyymmdd / hhmmss halves.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcheck_front (
  input  dtcheck_pkg::rec_in_t rec_i,
  output dtcheck_pkg::cls_t    cls_o
);

  localparam logic [13:0] YearScale = 14'd10000;
  localparam logic [13:0] MidScale  = 14'd100;
  localparam logic [12:0] Recip25   = 13'd5243;  // ceil(2^17 / 25)
  localparam logic [4:0]  Div25     = 5'd25;
  localparam logic [3:0]  MonthMax  = 4'd12;
  localparam logic [4:0]  HourMax   = 5'd23;
  localparam logic [5:0]  MinSecMax = 6'd59;
  localparam logic [4:0]  Days31    = 5'd31;
  localparam logic [4:0]  Days30    = 5'd30;
  localparam logic [4:0]  Days29    = 5'd29;
  localparam logic [4:0]  Days28    = 5'd28;

  logic [26:0] q25_prod;
  logic [9:0]  q25;
  logic [13:0] r25;
  logic        by25;
  logic        leap;
  logic [4:0]  mdays;
  logic        ok;

  // year mod 25 via reciprocal; exact for 14-bit years
  assign q25_prod = 27'(rec_i.year_num) * 27'(Recip25);
  assign q25      = q25_prod[26:17];
  assign r25      = rec_i.year_num - 14'(15'(q25) * 15'(Div25));
  assign by25     = (r25 == 14'd0);

  // div by 400 == div by 16 and 25; div by 100 == div by 4 and 25
  assign leap = (rec_i.year_num[1:0] == 2'd0) &&
                (!by25 || (rec_i.year_num[3:0] == 4'd0));

  always_comb begin
    unique case (rec_i.month_num) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: mdays = Days31;
      4'd4, 4'd6, 4'd9, 4'd11:                    mdays = Days30;
      default:                                    mdays = leap ? Days29 : Days28;
    endcase
  end

  assign ok = (rec_i.year_num != 14'd0) &&
              (rec_i.month_num != 4'd0) && (rec_i.month_num <= MonthMax) &&
              (rec_i.day_of_month != 5'd0) && (rec_i.day_of_month <= mdays) &&
              (rec_i.hour_num <= HourMax) &&
              (rec_i.minute_num <= MinSecMax) &&
              (rec_i.second_num <= MinSecMax);

  always_comb begin
    cls_o.ok   = ok;
    cls_o.date = dtcheck_pkg::DateW'(rec_i.year_num) * dtcheck_pkg::DateW'(YearScale) +
                 dtcheck_pkg::DateW'(rec_i.month_num) * dtcheck_pkg::DateW'(MidScale) +
                 dtcheck_pkg::DateW'(rec_i.day_of_month);
    cls_o.tod  = dtcheck_pkg::TodW'(rec_i.hour_num) * dtcheck_pkg::TodW'(YearScale) +
                 dtcheck_pkg::TodW'(rec_i.minute_num) * dtcheck_pkg::TodW'(MidScale) +
                 dtcheck_pkg::TodW'(rec_i.second_num);
    cls_o.record_id    = rec_i.record_id;
    cls_o.amount_cents = rec_i.amount_cents;
  end

endmodule

`default_nettype wire

>>> sv/dtcheck_fifo.sv
// ----------------------------------------------------------------------------
// dtcheck_fifo
// Short queue of classified records between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcheck_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  dtcheck_pkg::cls_t wr_data_i,
  output logic              full_o,
  input  logic              rd_en_i,
  output logic              rd_valid_o,
  output dtcheck_pkg::cls_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dtcheck_pkg::cls_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o     = (cnt_q == FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/dtcheck_back.sv
// ----------------------------------------------------------------------------
// dtcheck_back
// Key multiply stage, then the accumulator update into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcheck_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  dtcheck_pkg::cls_t     q_data_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output dtcheck_pkg::rec_out_t out_data_o
);

  localparam int unsigned StampW = dtcheck_pkg::StampW;
  localparam int unsigned CountW = dtcheck_pkg::CountW;
  localparam int unsigned SumW   = dtcheck_pkg::SumW;
  localparam int unsigned AmtW   = dtcheck_pkg::AmtW;
  localparam int unsigned IdW    = dtcheck_pkg::IdW;
  localparam logic [19:0]       KeyScale = 20'd1000000;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [SumW-1:0]   SumMax   = '1;

  typedef struct packed {
    logic              ok;
    logic [StampW-1:0] key;
    logic [IdW-1:0]    record_id;
    logic [AmtW-1:0]   amount_cents;
  } keyed_t;

  // key stage
  logic   a_valid_q;
  keyed_t a_q, a_d;
  logic   a_ready;
  logic [47:0] key_prod;

  // result stage and accumulators
  logic                  o_valid_q, o_valid_d;
  logic                  out_free;
  dtcheck_pkg::rec_out_t out_q, out_d;

  logic [CountW-1:0] good_q, good_d;
  logic [CountW-1:0] bad_q, bad_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [AmtW-1:0]   top_amt_q, top_amt_d, low_amt_q, low_amt_d;
  logic [IdW-1:0]    top_id_q, top_id_d, low_id_q, low_id_d;
  logic [StampW-1:0] top_stamp_q, top_stamp_d, low_stamp_q, low_stamp_d;
  logic [SumW:0]     sum_wide;
  logic              first;
  logic              adv;

  assign out_free = !o_valid_q || pop_i;
  assign a_ready  = !a_valid_q || out_free;
  assign q_pop_o  = q_valid_i && a_ready;
  assign adv      = a_valid_q && out_free;

  assign key_prod = 48'(q_data_i.date) * 48'(KeyScale);

  always_comb begin
    a_d.ok           = q_data_i.ok;
    a_d.key          = q_data_i.ok ?
                       (key_prod[StampW-1:0] + StampW'(q_data_i.tod)) : '0;
    a_d.record_id    = q_data_i.record_id;
    a_d.amount_cents = q_data_i.amount_cents;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_q <= a_d;
    end
  end

  // accumulator update for the record leaving the key stage
  assign first    = (good_q == '0);
  assign sum_wide = {1'b0, sum_q} + (SumW + 1)'(a_q.amount_cents);

  always_comb begin
    good_d      = good_q;
    bad_d       = bad_q;
    sum_d       = sum_q;
    top_amt_d   = top_amt_q;
    top_id_d    = top_id_q;
    top_stamp_d = top_stamp_q;
    low_amt_d   = low_amt_q;
    low_id_d    = low_id_q;
    low_stamp_d = low_stamp_q;
    if (a_q.ok) begin
      if (good_q != CountMax) begin
        good_d = good_q + CountW'(1);
      end
      sum_d = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
      if (first || (a_q.amount_cents > top_amt_q)) begin
        top_amt_d   = a_q.amount_cents;
        top_id_d    = a_q.record_id;
        top_stamp_d = a_q.key;
      end
      if (first || (a_q.amount_cents < low_amt_q)) begin
        low_amt_d   = a_q.amount_cents;
        low_id_d    = a_q.record_id;
        low_stamp_d = a_q.key;
      end
    end else if (bad_q != CountMax) begin
      bad_d = bad_q + CountW'(1);
    end
  end

  always_comb begin
    out_d.record_valid        = a_q.ok;
    out_d.record_stamp        = a_q.key;
    out_d.valid_total_count   = good_d;
    out_d.invalid_total_count = bad_d;
    out_d.amount_sum          = sum_d;
    out_d.largest_amount      = top_amt_d;
    out_d.largest_id          = top_id_d;
    out_d.largest_stamp       = top_stamp_d;
    out_d.smallest_amount     = low_amt_d;
    out_d.smallest_id         = low_id_d;
    out_d.smallest_stamp      = low_stamp_d;
  end

  always_comb begin
    o_valid_d = o_valid_q;
    if (out_free) begin
      o_valid_d = a_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q   <= 1'b0;
      good_q      <= '0;
      bad_q       <= '0;
      sum_q       <= '0;
      top_amt_q   <= '0;
      top_id_q    <= '0;
      top_stamp_q <= '0;
      low_amt_q   <= '0;
      low_id_q    <= '0;
      low_stamp_q <= '0;
    end else begin
      o_valid_q <= o_valid_d;
      if (adv) begin
        good_q      <= good_d;
        bad_q       <= bad_d;
        sum_q       <= sum_d;
        top_amt_q   <= top_amt_d;
        top_id_q    <= top_id_d;
        top_stamp_q <= top_stamp_d;
        low_amt_q   <= low_amt_d;
        low_id_q    <= low_id_d;
        low_stamp_q <= low_stamp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign empty_o    = !o_valid_q;
  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  a_invalid_no_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && !out_q.record_valid |-> out_q.record_stamp == '0)
    else $error("invalid record carries a nonzero stamp");

  a_good_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> good_q >= $past(good_q))
    else $error("valid count went down");

  a_extremes_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_q != '0 |-> low_amt_q <= top_amt_q)
    else $error("smallest amount above largest amount");

  a_no_valid_zero_extremes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_q == '0 |-> top_amt_q == '0 && low_amt_q == '0 && sum_q == '0)
    else $error("accumulators moved without a valid record");
`endif

endmodule

`default_nettype wire

>>> sv/datetime_check_min_max_sum.sv
// ----------------------------------------------------------------------------
// datetime_check_min_max_sum
// Gregorian date-time check per record with running valid/invalid counts,
// saturating amount sum, and largest / smallest amount with id and key.
// ----------------------------------------------------------------------------
//
//   channel  | ports                   | transfer when
//   ---------+-------------------------+------------------------
//   records  | push, full, in_data_i   | push && !full
//   results  | empty, pop, out_data_o  | pop && !empty
//
// One record per cycle sustained while results are popped; the accumulator
// compare-update is a single registered step, so it sets the rate.
// A pushed record passes the queue write, the key multiply stage and the
// accumulator / result register before its result shows.
// Reset clears the queue, the pipeline valids and all accumulators.
// A stalled result (pop low) holds the back end; the queue of FifoDepth
// records keeps taking pushes until it fills, then full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module datetime_check_min_max_sum #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  dtcheck_pkg::rec_in_t  in_data_i,
  output logic                  empty,
  input  logic                  pop,
  output dtcheck_pkg::rec_out_t out_data_o
);

  dtcheck_pkg::cls_t cls;       // classified record from the front end
  dtcheck_pkg::cls_t q_data;    // head of the queue
  logic              q_valid;
  logic              q_pop;

  // Front end: calendar check and key halves, straight into the queue.
  dtcheck_front u_front (
    .rec_i (in_data_i),
    .cls_o (cls)
  );

  // Decoupling queue; its full flag is the input backpressure.
  dtcheck_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_data_i  (cls),
    .full_o     (full),
    .rd_en_i    (q_pop),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_data)
  );

  // Back end: key multiply, then accumulators and the result register.
  dtcheck_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> sim/datetime_check_min_max_sum_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// datetime_check_min_max_sum_tb
// Pushes date-time records through the checker and compares every result
// against a cycle-free scoreboard that tracks counts, sum and extremes.
// ----------------------------------------------------------------------------
module datetime_check_min_max_sum_tb;

  localparam int unsigned WatchdogLimit = 2000;  // cycles with no transfer
  localparam int unsigned TailCycles    = 8;     // pipeline is 2 deep, plus margin
  localparam int unsigned RandomPerPhase = 450;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  logic                  pop       = 1'b0;
  logic                  full;
  logic                  empty;
  dtcheck_pkg::rec_in_t  in_data_i = '0;
  dtcheck_pkg::rec_out_t out_data_o;

  datetime_check_min_max_sum dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Scoreboard state: mirrors the block's accumulators, all zero after reset.
  // --------------------------------------------------------------------------
  logic [dtcheck_pkg::CountW-1:0] seen_good    = '0;
  logic [dtcheck_pkg::CountW-1:0] seen_bad     = '0;
  logic [dtcheck_pkg::SumW-1:0]   amount_total = '0;
  logic [dtcheck_pkg::AmtW-1:0]   max_amt      = '0;
  logic [dtcheck_pkg::IdW-1:0]    max_id       = '0;
  logic [dtcheck_pkg::StampW-1:0] max_key      = '0;
  logic [dtcheck_pkg::AmtW-1:0]   min_amt      = '0;
  logic [dtcheck_pkg::IdW-1:0]    min_id       = '0;
  logic [dtcheck_pkg::StampW-1:0] min_key      = '0;

  dtcheck_pkg::rec_out_t pending_totals[$];   // expected results, oldest first
  int unsigned records_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches     = 0;

  // Traffic shaping, set by the test tasks.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_len    = 0;     // length of a requested receiver hold-off
  int unsigned hold_token  = 0;     // bumped by a test to request a hold-off
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  function automatic bit is_leap(int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      default:               return is_leap(y) ? 29 : 28;
    endcase
  endfunction

  // Classify one record, fold it into the accumulators and return what the
  // block should show for it.
  function automatic dtcheck_pkg::rec_out_t tally_record(dtcheck_pkg::rec_in_t r);
    dtcheck_pkg::rec_out_t        o;
    bit                           ok;
    bit                           first;
    longint unsigned              date_part;
    longint unsigned              time_part;
    longint unsigned              stamp;
    logic [dtcheck_pkg::SumW:0]   wide_sum;
    ok = (r.year_num != 0) && (r.month_num >= 1) && (r.month_num <= 12) &&
         (r.day_of_month >= 1) &&
         (r.day_of_month <= days_in_month(r.month_num, r.year_num)) &&
         (r.hour_num <= 23) && (r.minute_num <= 59) && (r.second_num <= 59);
    stamp = 0;
    if (ok) begin
      first     = (seen_good == 0);
      date_part = longint'(r.year_num) * 10000 + longint'(r.month_num) * 100 +
                  longint'(r.day_of_month);
      time_part = longint'(r.hour_num) * 10000 + longint'(r.minute_num) * 100 +
                  longint'(r.second_num);
      // years above 14073 overflow the 47-bit key and wrap
      stamp = (date_part * 1000000 + time_part) & ((64'd1 << dtcheck_pkg::StampW) - 1);
      if (seen_good != '1) seen_good = seen_good + 1;
      wide_sum     = {1'b0, amount_total} + r.amount_cents;
      amount_total = wide_sum[dtcheck_pkg::SumW] ? '1 : wide_sum[dtcheck_pkg::SumW-1:0];
      // strict compares: on a tie the earlier record stays
      if (first || r.amount_cents > max_amt) begin
        max_amt = r.amount_cents;
        max_id  = r.record_id;
        max_key = stamp[dtcheck_pkg::StampW-1:0];
      end
      if (first || r.amount_cents < min_amt) begin
        min_amt = r.amount_cents;
        min_id  = r.record_id;
        min_key = stamp[dtcheck_pkg::StampW-1:0];
      end
    end else if (seen_bad != '1) begin
      seen_bad = seen_bad + 1;
    end
    o.record_valid        = ok;
    o.record_stamp        = stamp[dtcheck_pkg::StampW-1:0];
    o.valid_total_count   = seen_good;
    o.invalid_total_count = seen_bad;
    o.amount_sum          = amount_total;
    o.largest_amount      = max_amt;
    o.largest_id          = max_id;
    o.largest_stamp       = max_key;
    o.smallest_amount     = min_amt;
    o.smallest_id         = min_id;
    o.smallest_stamp      = min_key;
    return o;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: a transfer on the record side queues its expected result, a
  // transfer on the result side is checked against the oldest one. Results
  // come only after their record has crossed the queue, so order here is free.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    dtcheck_pkg::rec_out_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_totals.size() == 0) begin
          $display("%0t: result with no record waiting, actual %h", $time, out_data_o);
          mismatches++;
        end else begin
          want = pending_totals.pop_front();
          check_field("record_valid", want.record_valid, out_data_o.record_valid);
          check_field("record_stamp", want.record_stamp, out_data_o.record_stamp);
          check_field("valid_total_count", want.valid_total_count,
                      out_data_o.valid_total_count);
          check_field("invalid_total_count", want.invalid_total_count,
                      out_data_o.invalid_total_count);
          check_field("amount_sum", want.amount_sum, out_data_o.amount_sum);
          check_field("largest_amount", want.largest_amount, out_data_o.largest_amount);
          check_field("largest_id", want.largest_id, out_data_o.largest_id);
          check_field("largest_stamp", want.largest_stamp, out_data_o.largest_stamp);
          check_field("smallest_amount", want.smallest_amount, out_data_o.smallest_amount);
          check_field("smallest_id", want.smallest_id, out_data_o.smallest_id);
          check_field("smallest_stamp", want.smallest_stamp, out_data_o.smallest_stamp);
          results_checked++;
        end
      end
      if (push && !full) begin
        pending_totals.push_back(tally_record(in_data_i));
        records_sent++;
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either side for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
               $time, WatchdogLimit, pending_totals.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random pop, or a hold-off set by hold_len when a test asks.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= hold_len;
      pop       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender: optional idle cycles, then offer the record until it transfers.
  // push stays high on return so back-to-back records need no re-raise.
  // --------------------------------------------------------------------------
  task automatic send_record(dtcheck_pkg::rec_in_t rec);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= rec;
    do begin
      @(posedge clk_i);
    end while (full);
  endtask

  // Stop offering and wait until every expected result has been popped.
  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
  endtask

  function automatic dtcheck_pkg::rec_in_t make_record(
      int unsigned d, int unsigned m, int unsigned y,
      int unsigned h, int unsigned mi, int unsigned s,
      int unsigned id, int unsigned amt);
    dtcheck_pkg::rec_in_t r;
    r.day_of_month = 5'(d);
    r.month_num    = 4'(m);
    r.year_num     = 14'(y);
    r.hour_num     = 5'(h);
    r.minute_num   = 6'(mi);
    r.second_num   = 6'(s);
    r.record_id    = 16'(id);
    r.amount_cents = 24'(amt);
    return r;
  endfunction

  // Mostly well-formed records with random content; the rest is raw noise or
  // a good record with one field pushed out of range.
  function automatic dtcheck_pkg::rec_in_t random_record();
    dtcheck_pkg::rec_in_t r;
    int unsigned          pick;
    int unsigned          yy;
    int unsigned          mm;
    int unsigned          dd_max;
    pick = $urandom_range(99);
    if (pick < 12) begin
      r = make_record($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
      return r;
    end
    yy     = ($urandom_range(9) == 0) ? $urandom_range(1, 16383) : $urandom_range(1, 9999);
    mm     = $urandom_range(1, 12);
    dd_max = days_in_month(mm, yy);
    r = make_record($urandom_range(1, dd_max), mm, yy, $urandom_range(0, 23),
                    $urandom_range(0, 59), $urandom_range(0, 59), $urandom, $urandom);
    case ($urandom_range(9))
      0:       r.amount_cents = '0;
      1:       r.amount_cents = '1;
      2:       r.amount_cents = max_amt;   // likely tie with the current largest
      3:       r.amount_cents = min_amt;   // likely tie with the current smallest
      default: ;
    endcase
    if (pick < 25) begin
      case ($urandom_range(5))
        0: r.year_num   = '0;
        1: r.month_num  = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
        2: r.day_of_month = (dd_max == 31 || $urandom_range(1) == 0) ?
                            5'd0 : 5'($urandom_range(dd_max + 1, 31));
        3: r.hour_num   = 5'($urandom_range(24, 31));
        4: r.minute_num = 6'($urandom_range(60, 63));
        default: r.second_num = 6'($urandom_range(60, 63));
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field limits, calendar corners, seeding, ties and key wrap.
  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_record(make_record(1, 1, 0, 0, 0, 0, 100, 77));                // year 0, nothing seeded yet
    send_record(make_record(1, 1, 1, 0, 0, 0, 1, 500));                 // first valid seeds both
    send_record(make_record(31, 12, 9999, 23, 59, 59, 2, 500));         // tie on both ends
    send_record(make_record(15, 6, 2010, 12, 30, 30, 3, 24'hFFFFFF));   // new largest
    send_record(make_record(15, 6, 2011, 1, 2, 3, 4, 0));               // new smallest
    send_record(make_record(16, 6, 2011, 1, 2, 3, 5, 0));               // tie on smallest
    send_record(make_record(17, 6, 2011, 1, 2, 3, 6, 24'hFFFFFF));      // tie on largest
    send_record(make_record(29, 2, 2000, 0, 0, 0, 7, 1234));            // leap by 400
    send_record(make_record(29, 2, 1900, 0, 0, 0, 8, 1234));            // century, not leap
    send_record(make_record(29, 2, 2024, 0, 0, 0, 9, 1234));            // leap by 4
    send_record(make_record(29, 2, 2023, 0, 0, 0, 10, 1234));           // common year
    send_record(make_record(28, 2, 2023, 0, 0, 0, 11, 1234));
    send_record(make_record(30, 2, 2024, 0, 0, 0, 12, 1234));
    send_record(make_record(31, 4, 2023, 0, 0, 0, 13, 1234));           // 30-day month
    send_record(make_record(30, 4, 2023, 0, 0, 0, 14, 1234));
    send_record(make_record(1, 0, 2023, 0, 0, 0, 15, 1234));            // month out of range
    send_record(make_record(1, 13, 2023, 0, 0, 0, 16, 1234));
    send_record(make_record(31, 15, 16383, 31, 63, 63, 17, 1234));      // all fields at max
    send_record(make_record(0, 1, 2023, 0, 0, 0, 18, 1234));            // day 0
    send_record(make_record(1, 1, 2023, 24, 0, 0, 19, 1234));           // hour, minute, second
    send_record(make_record(1, 1, 2023, 0, 60, 0, 20, 1234));
    send_record(make_record(1, 1, 2023, 0, 0, 60, 21, 1234));
    send_record(make_record(31, 12, 14073, 23, 59, 59, 22, 1234));      // last key without wrap
    send_record(make_record(1, 1, 14074, 0, 0, 0, 23, 1234));           // key wraps
    send_record(make_record(31, 12, 16383, 23, 59, 59, 16'hFFFF, 1234));
  endtask

  // Receiver holds off while the sender keeps offering, so full must rise.
  task automatic test_full_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(posedge clk_i);
    hold_len   = 80;
    hold_token = hold_token + 1;
    repeat (20) send_record(random_record());
  endtask

  task automatic test_random(int unsigned count, int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_record(random_record());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    drain_results();
    test_full_stall();
    drain_results();              // sender pauses until the block is empty
    test_random(RandomPerPhase, 35, 52);
    test_random(RandomPerPhase, 52, 35);
    test_random(RandomPerPhase, 0, 0);
    drain_results();
    repeat (TailCycles) @(posedge clk_i);   // catch any stray late result

    $display("Run covered %0d records (%0d valid, %0d invalid), %0d results compared.",
             records_sent, seen_good, seen_bad, results_checked);
    $display("Included calendar corners, ties, key wrap, a full-queue stall and idle mixes.");
    if (mismatches == 0 && pending_totals.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
